>>> hw/rtl/sle_pkg.sv
// Shared types and constants of the string literal escape encoder.
// Used by sle_decode, sle_burst and the top level; depends on nothing.
package sle_pkg;

   // Largest number of output bytes one input item can cause.
   localparam int MAX_BURST   = 8;
   localparam int BURST_CNT_W = $clog2(MAX_BURST + 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_WORD_WIDTH_CODE = 1'b0;

   // Element width codes.
   localparam logic [1:0] WIDTH_BYTE = 2'd0;
   localparam logic [1:0] WIDTH_HALF = 2'd1;
   localparam logic [1:0] WIDTH_WORD = 2'd2;

   // Error codes carried on the first byte of an element.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
   localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_BACKSLASH = 3'd1,
      MODE_HEX       = 3'd2,
      MODE_UNI       = 3'd3,
      MODE_OCT       = 3'd4
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] value;
      logic [3:0]  digits;
      logic        overflow;
      logic        long_uni;
   } esc_state_type;

   localparam esc_state_type ESC_IDLE = '{
      mode: MODE_IDLE, value: 32'd0, digits: 4'd0, overflow: 1'b0, long_uni: 1'b0
   };

   typedef struct packed {
      logic [MAX_BURST-1:0][7:0] data;
      logic [MAX_BURST-1:0][1:0] err;
      logic [BURST_CNT_W-1:0]    count;
   } burst_type;

endpackage

>>> hw/rtl/string_literal_escape_encoder.sv
// An accepted item is held in the input register, decoded combinationally and loaded
// into the result buffer, which drives the output byte.
// Throughput: one item per cycle while each item yields at most one byte and the output
// is not stalled; an item that yields K bytes (up to 8) holds the single output byte port
// until all K bytes are taken. Items that only add an escape digit yield no byte.
// Reset is synchronous: escape state idle, both buffers empty, element width code 0.
module string_literal_escape_encoder (
   input  logic                           clock,
   input  logic                           reset,
   // Input item channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_in_byte,
   input  logic                           req_piece_end,
   // Result item channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic [1:0]                     rsp_error_code,
   output logic                           rsp_run_last,
   // Configuration port.
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sle_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import sle_pkg::*;

   // The input register takes an item whenever it is empty or is being emptied,
   // so a new item is accepted while the result buffer is stalled if the register is empty.
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   logic          in_end_ff, in_end_in;
   logic          req_take;
   logic          in_move;

   // Escape state advances only when an item moves into the result buffer.
   esc_state_type esc_ff, esc_in;
   esc_state_type esc_next;
   burst_type     burst;
   logic          burst_ready;

   logic [1:0]    width_ff, width_in;
   logic          csr_write;

   // Configuration: one register, the element width code, at word 0.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_WORD_WIDTH_CODE) ? {30'd0, width_ff} : 32'd0;

   always_comb begin
      width_in = width_ff;
      if (csr_write && (csr_paddr[2] == CSR_WORD_WIDTH_CODE)) begin
         width_in = csr_pwdata[1:0];
      end
   end

   // Input register handshake.
   assign in_move   = in_valid_ff && burst_ready;
   assign req_stall = in_valid_ff && !burst_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
         in_end_in   = req_piece_end;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
   end

   assign esc_in = in_move ? esc_next : esc_ff;

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         esc_ff      <= ESC_IDLE;
         width_ff    <= WIDTH_BYTE;
      end else begin
         in_valid_ff <= in_valid_in;
         esc_ff      <= esc_in;
         width_ff    <= width_in;
      end
   end

   // Decode the held byte against the escape state into a burst of up to
   // eight output bytes from at most two elements, each of up to four bytes.
   sle_decode u_decode (
      .cur_state  (esc_ff),
      .in_byte    (in_byte_ff),
      .piece_end  (in_end_ff),
      .width_code (width_ff),
      .next_state (esc_next),
      .burst      (burst)
   );

   // The result buffer streams the burst out; an empty burst frees it at once.
   sle_burst u_burst (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (in_valid_ff),
      .load_burst     (burst),
      .load_ready     (burst_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_error_code (rsp_error_code),
      .rsp_run_last   (rsp_run_last)
   );

`ifndef SYNTHESIS
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !burst_ready |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_end_ff))
      else $error("held input item was lost before decode");

   a_piece_closes: assert property (@(posedge clock) disable iff (reset)
      in_move && in_end_ff |=> esc_ff.mode == MODE_IDLE)
      else $error("escape left open across a piece end");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !in_move |=> $stable(esc_ff))
      else $error("escape state changed without a decoded item");
`endif

endmodule

>>> hw/rtl/sle_decode.sv
// Escape decoder: next escape state and the output bytes of one input item.
// Purely combinational; depends on sle_pkg.
module sle_decode (
   input  sle_pkg::esc_state_type cur_state,
   input  logic [7:0]             in_byte,
   input  logic                   piece_end,
   input  logic [1:0]             width_code,
   output sle_pkg::esc_state_type next_state,
   output sle_pkg::burst_type     burst
);
   import sle_pkg::*;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_QMARK     = 8'h3F;
   localparam logic [7:0] CH_A         = 8'h61;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_V         = 8'h76;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_U_LOW     = 8'h75;
   localparam logic [7:0] CH_U_UP      = 8'h55;
   localparam logic [7:0] CH_0         = 8'h30;
   localparam logic [7:0] CH_7         = 8'h37;
   localparam logic [7:0] CH_9         = 8'h39;
   localparam logic [7:0] CH_A_UP      = 8'h41;
   localparam logic [7:0] CH_F_UP      = 8'h46;

   typedef struct packed {
      logic        valid;
      logic        unicode;
      logic [31:0] value;
      logic [1:0]  err;
   } elem_type;

   typedef struct packed {
      logic [3:0][7:0] data;
      logic [3:0][1:0] err;
      logic [2:0]      n;
   } enc_type;

   function automatic elem_type plain_elem(input logic [31:0] v, input logic [1:0] e);
      elem_type r;
      r = '0;
      r.valid = 1'b1;
      r.value = v;
      r.err   = e;
      return r;
   endfunction

   // Value of the open escape as it stands when the escape is closed.
   function automatic elem_type close_elem(input esc_state_type s, input logic [31:0] mx);
      elem_type   r;
      logic [3:0] need;
      r = '0;
      r.valid = 1'b1;
      need = s.long_uni ? 4'd8 : 4'd4;
      case (s.mode)
         MODE_BACKSLASH: r.err = ERR_UNKNOWN;
         MODE_HEX: begin
            if (s.digits == 4'd0) begin
               r.err = ERR_UNKNOWN;
            end else if (s.overflow || (s.value > mx)) begin
               r.value = s.value & mx;
               r.err   = ERR_TOO_LARGE;
            end else begin
               r.value = s.value;
            end
         end
         MODE_UNI: begin
            r.unicode = 1'b1;
            r.value   = s.value;
            r.err     = (s.digits < need) ? ERR_UNKNOWN : ERR_NONE;
         end
         MODE_OCT: begin
            if (s.value > mx) begin
               r.value = s.value & mx;
               r.err   = ERR_TOO_LARGE;
            end else begin
               r.value = s.value;
            end
         end
         default: r.valid = 1'b0;
      endcase
      return r;
   endfunction

   // Bytes of one element: UTF-8 for unicode at byte width, else little endian.
   function automatic enc_type encode(input elem_type el, input logic [1:0] wc);
      enc_type     r;
      logic [31:0] v;
      r = '0;
      v = el.value;
      if (!el.valid) begin
         r.n = 3'd0;
      end else if (el.unicode && (wc == WIDTH_BYTE)) begin
         r.err[0] = el.err;
         if (v < 32'h80) begin
            r.n       = 3'd1;
            r.data[0] = v[7:0];
         end else if (v < 32'h800) begin
            r.n       = 3'd2;
            r.data[0] = 8'hC0 | {3'b000, v[10:6]};
            r.data[1] = 8'h80 | {2'b00, v[5:0]};
         end else if (v < 32'h10000) begin
            r.n       = 3'd3;
            r.data[0] = 8'hE0 | {4'b0000, v[15:12]};
            r.data[1] = 8'h80 | {2'b00, v[11:6]};
            r.data[2] = 8'h80 | {2'b00, v[5:0]};
         end else begin
            r.n       = 3'd4;
            r.data[0] = 8'hF0 | v[25:18];
            r.data[1] = 8'h80 | {2'b00, v[17:12]};
            r.data[2] = 8'h80 | {2'b00, v[11:6]};
            r.data[3] = 8'h80 | {2'b00, v[5:0]};
         end
      end else begin
         r.err[0] = el.err;
         r.data   = v;
         case (wc)
            WIDTH_BYTE: r.n = 3'd1;
            WIDTH_HALF: r.n = 3'd2;
            default:    r.n = 3'd4;
         endcase
      end
      return r;
   endfunction

   logic [31:0]   elem_max;
   logic          is_hex;
   logic          is_oct;
   logic [3:0]    hex_val;
   logic [3:0]    need_uni;
   elem_type      e0;
   elem_type      e1;
   esc_state_type st;
   logic          run_idle;
   enc_type       enc0;
   enc_type       enc1;

   always_comb begin
      case (width_code)
         WIDTH_BYTE: elem_max = 32'h0000_00FF;
         WIDTH_HALF: elem_max = 32'h0000_FFFF;
         default:    elem_max = 32'hFFFF_FFFF;
      endcase
   end

   assign is_oct  = (in_byte >= CH_0) && (in_byte <= CH_7);
   assign is_hex  = ((in_byte >= CH_0) && (in_byte <= CH_9))
                 || ((in_byte >= CH_A) && (in_byte <= CH_F))
                 || ((in_byte >= CH_A_UP) && (in_byte <= CH_F_UP));
   // Letters a-f and A-F share their low nibble, one above the digit minus ten.
   assign hex_val = (in_byte <= CH_9) ? in_byte[3:0] : in_byte[3:0] + 4'd9;
   assign need_uni = cur_state.long_uni ? 4'd8 : 4'd4;

   always_comb begin
      st       = cur_state;
      e0       = '0;
      e1       = '0;
      run_idle = 1'b0;
      case (cur_state.mode)
         MODE_BACKSLASH: begin
            st = ESC_IDLE;
            case (in_byte) inside
               CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BACKSLASH:
                  e0 = plain_elem({24'd0, in_byte}, ERR_NONE);
               CH_A: e0 = plain_elem(32'd7, ERR_NONE);
               CH_B: e0 = plain_elem(32'd8, ERR_NONE);
               CH_F: e0 = plain_elem(32'd12, ERR_NONE);
               CH_N: e0 = plain_elem(32'd10, ERR_NONE);
               CH_R: e0 = plain_elem(32'd13, ERR_NONE);
               CH_T: e0 = plain_elem(32'd9, ERR_NONE);
               CH_V: e0 = plain_elem(32'd11, ERR_NONE);
               CH_X: st.mode = MODE_HEX;
               CH_U_LOW, CH_U_UP: begin
                  st.mode     = MODE_UNI;
                  st.long_uni = (in_byte == CH_U_UP);
               end
               [CH_0:CH_7]: begin
                  st.mode   = MODE_OCT;
                  st.value  = {29'd0, in_byte[2:0]};
                  st.digits = 4'd1;
               end
               default: e0 = plain_elem({{24{in_byte[7]}}, in_byte}, ERR_UNKNOWN);
            endcase
         end
         MODE_HEX: begin
            if (is_hex) begin
               if (cur_state.value[31:28] != 4'd0) begin
                  st.overflow = 1'b1;
               end
               st.value = {cur_state.value[27:0], hex_val};
               if (cur_state.digits < 4'd15) begin
                  st.digits = cur_state.digits + 4'd1;
               end
            end else begin
               e0       = close_elem(cur_state, elem_max);
               st       = ESC_IDLE;
               run_idle = 1'b1;
            end
         end
         MODE_UNI: begin
            if (is_hex) begin
               st.value  = {cur_state.value[27:0], hex_val};
               st.digits = cur_state.digits + 4'd1;
               if (st.digits >= need_uni) begin
                  e0 = close_elem(st, elem_max);
                  st = ESC_IDLE;
               end
            end else begin
               e0       = close_elem(cur_state, elem_max);
               st       = ESC_IDLE;
               run_idle = 1'b1;
            end
         end
         MODE_OCT: begin
            if (is_oct) begin
               st.value  = {cur_state.value[28:0], in_byte[2:0]};
               st.digits = cur_state.digits + 4'd1;
               if (st.digits >= 4'd3) begin
                  e0 = close_elem(st, elem_max);
                  st = ESC_IDLE;
               end
            end else begin
               e0       = close_elem(cur_state, elem_max);
               st       = ESC_IDLE;
               run_idle = 1'b1;
            end
         end
         default: begin
            st       = ESC_IDLE;
            run_idle = 1'b1;
         end
      endcase

      // A closing or idle byte is plain text; a backslash opens a new escape.
      if (run_idle) begin
         if (in_byte == CH_BACKSLASH) begin
            st.mode = MODE_BACKSLASH;
         end else if (!e0.valid) begin
            e0 = plain_elem({24'd0, in_byte}, ERR_NONE);
         end else begin
            e1 = plain_elem({24'd0, in_byte}, ERR_NONE);
         end
      end

      // An escape still open at the end of a piece is closed here.
      if (piece_end && (st.mode != MODE_IDLE)) begin
         if (!e0.valid) begin
            e0 = close_elem(st, elem_max);
         end else begin
            e1 = close_elem(st, elem_max);
         end
         st = ESC_IDLE;
      end
   end

   assign next_state = st;
   assign enc0 = encode(e0, width_code);
   assign enc1 = encode(e1, width_code);

   always_comb begin
      logic [3:0] pos;
      logic [3:0] rel;
      burst = '0;
      burst.count = BURST_CNT_W'({1'b0, enc0.n} + {1'b0, enc1.n});
      for (int k = 0; k < MAX_BURST; k++) begin
         pos = 4'(k);
         rel = pos - {1'b0, enc0.n};
         if (pos < {1'b0, enc0.n}) begin
            burst.data[k] = enc0.data[pos[1:0]];
            burst.err[k]  = enc0.err[pos[1:0]];
         end else if (rel < {1'b0, enc1.n}) begin
            burst.data[k] = enc1.data[rel[1:0]];
            burst.err[k]  = enc1.err[rel[1:0]];
         end
      end
   end

endmodule

>>> hw/rtl/sle_burst.sv
// Result buffer: holds the bytes of one decoded item and sends them one a
// cycle while not stalled. Depends on sle_pkg.
module sle_burst (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  sle_pkg::burst_type  load_burst,
   output logic                load_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic [1:0]          rsp_error_code,
   output logic                rsp_run_last
);
   import sle_pkg::*;

   logic [MAX_BURST-1:0][7:0] data_ff, data_in;
   logic [MAX_BURST-1:0][1:0] err_ff, err_in;
   logic [BURST_CNT_W-1:0]    count_ff, count_in;
   logic                      busy;
   logic                      take;
   logic                      load;

   assign busy       = (count_ff != '0);
   assign take       = busy && !rsp_stall;
   assign load_ready = !busy || (take && (count_ff == BURST_CNT_W'(1)));
   assign load       = load_valid && load_ready;

   always_comb begin
      data_in  = data_ff;
      err_in   = err_ff;
      count_in = count_ff;
      if (load) begin
         data_in  = load_burst.data;
         err_in   = load_burst.err;
         count_in = load_burst.count;
      end else if (take) begin
         for (int i = 0; i < MAX_BURST - 1; i++) begin
            data_in[i] = data_ff[i+1];
            err_in[i]  = err_ff[i+1];
         end
         count_in = count_ff - BURST_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      err_ff  <= err_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_valid      = busy;
   assign rsp_out_byte   = data_ff[0];
   assign rsp_error_code = err_ff[0];
   assign rsp_run_last   = (count_ff == BURST_CNT_W'(1));

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= BURST_CNT_W'(MAX_BURST))
      else $error("result buffer holds more bytes than one item can cause");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      take && (count_ff > BURST_CNT_W'(1)) |=> count_ff == $past(count_ff) - BURST_CNT_W'(1))
      else $error("result buffer did not step by one byte");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      busy && rsp_stall |=> count_ff == $past(count_ff))
      else $error("result buffer changed while stalled");
`endif

endmodule
